@@ hw/rtl/ils_pkg.sv @@
// ils_pkg: shared types and codes for the indexed list store
// request and result structs, operation, status and sequencer codes
// no dependencies
`default_nettype none

package ils_pkg;

  localparam int CAPACITY_DEF    = 256;
  localparam int HANDLE_BITS_DEF = 32;

  // operation codes; code 7 is unused and ignored
  typedef enum logic [2:0] {
    KIND_APPEND = 3'd0,
    KIND_GET    = 3'd1,
    KIND_SET    = 3'd2,
    KIND_INSERT = 3'd3,
    KIND_REMOVE = 3'd4,
    KIND_FIND   = 3'd5,
    KIND_CLEAR  = 3'd6
  } kind_t;

  typedef enum logic [1:0] {
    STATUS_OK    = 2'd0,
    STATUS_NULL  = 2'd1,
    STATUS_RANGE = 2'd2,
    STATUS_FULL  = 2'd3
  } status_t;

  typedef enum logic [2:0] {
    SQ_IDLE,
    SQ_EXEC,
    SQ_PICK,
    SQ_SHUP,
    SQ_TAIL,
    SQ_SHDN,
    SQ_FIND,
    SQ_FIN
  } seq_state_t;

  typedef struct packed {
    logic [2:0]  kind;
    logic [8:0]  position;
    logic [31:0] element;
  } req_t;

  typedef struct packed {
    status_t     status;
    logic [31:0] element_out;
    logic [7:0]  found_position;
    logic        found;
    logic [8:0]  count;
    logic        empty_res;
  } rsp_t;

endpackage

`default_nettype wire

@@ hw/rtl/ils_mem.sv @@
// ils_mem: entry store, one write port and one registered read port
// no dependencies
`default_nettype none

module ils_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem_r[raddr];
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/indexed_list_store.sv @@
// indexed_list_store: ordered list of element handles with a count
// depends on ils_pkg and ils_mem
//
// usage
//   one request channel (in_valid / in_stall / in_req) and one result channel
//   (out_valid / out_stall / out_rsp); every request gives exactly one result
//   a request is taken when in_valid is high and in_stall low; in_stall stays
//   high from the cycle after a request is taken until its result has been
//   written into the output register
// sequencing
//   append, set, clear and errors end in the check state; get also reads;
//   find compares the stored entries in order; insert moves the entries
//   from the position on up by one, remove moves those behind it down by
//   one; shifts and search go through the single read and write port of
//   the entry store (one entry moved or compared per cycle); one request
//   at a time, the next is taken the cycle after a result is loaded
// reset
//   rst_n (synchronous, active low) empties the list and drops any pending
//   result; stored entries are not cleared, only the count
// back pressure
//   a finished result waits in the output register while out_stall is high;
//   the sequencer holds its last state until the register frees up
`default_nettype none

module indexed_list_store #(
  parameter int CAPACITY    = ils_pkg::CAPACITY_DEF,
  parameter int HANDLE_BITS = ils_pkg::HANDLE_BITS_DEF
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          in_valid,
  output logic               in_stall,
  input  wire ils_pkg::req_t in_req,
  output logic               out_valid,
  input  wire logic          out_stall,
  output ils_pkg::rsp_t      out_rsp
);

  import ils_pkg::*;

  localparam int AW    = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  // compare width: holds count, position and small offsets without overflow
  localparam int CW    = (CNT_W > 9) ? CNT_W : 9;
  localparam int XW    = CW + 1;
  // handle bits that survive the 32-bit field and the handle mask
  localparam int EW    = (HANDLE_BITS < 32) ? HANDLE_BITS : 32;

  // sequencer and list state
  seq_state_t             state_r, state_nxt;
  logic [CNT_W-1:0]       count_r, count_nxt;
  logic [CNT_W-1:0]       idx_r, idx_nxt;

  // latched request
  logic [2:0]             kind_r;
  logic [8:0]             pos_r;
  logic [HANDLE_BITS-1:0] elem_r;

  // result under construction
  status_t                status_r, status_nxt;
  logic [HANDLE_BITS-1:0] eout_r, eout_nxt;
  logic                   found_r, found_nxt;
  logic [CNT_W-1:0]       fpos_r, fpos_nxt;

  // output register
  rsp_t                   out_rsp_r;
  logic                   out_valid_r;
  logic                   out_load;
  logic                   out_free;

  // entry store ports
  logic                   mem_we;
  logic [AW-1:0]          mem_waddr;
  logic [HANDLE_BITS-1:0] mem_wdata;
  logic                   mem_re;
  logic [AW-1:0]          mem_raddr;
  logic [HANDLE_BITS-1:0] mem_rdata;

  // widened views for range compares
  logic [XW-1:0]          cnt_w, pos_w, idx_w;
  logic                   full;
  logic                   elem_null;
  logic                   req_take;

  assign cnt_w     = XW'(count_r);
  assign pos_w     = XW'(pos_r);
  assign idx_w     = XW'(idx_r);
  assign full      = (count_r == CNT_W'(CAPACITY));
  assign elem_null = (elem_r == '0);

  assign in_stall  = (state_r != SQ_IDLE);
  assign req_take  = in_valid && !in_stall;
  assign out_free  = !out_valid_r || !out_stall;

  ils_mem #(
    .DEPTH (CAPACITY),
    .WIDTH (HANDLE_BITS)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  // request capture; the handle is masked to the stored width here
  always_ff @(posedge clk) begin
    if (req_take) begin
      kind_r <= in_req.kind;
      pos_r  <= in_req.position;
      elem_r <= HANDLE_BITS'(in_req.element[EW-1:0]);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= SQ_IDLE;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r    <= idx_nxt;
    status_r <= status_nxt;
    eout_r   <= eout_nxt;
    found_r  <= found_nxt;
    fpos_r   <= fpos_nxt;
  end

  // sequencer: one store access of each kind per cycle
  always_comb begin
    state_nxt  = state_r;
    count_nxt  = count_r;
    idx_nxt    = idx_r;
    status_nxt = status_r;
    eout_nxt   = eout_r;
    found_nxt  = found_r;
    fpos_nxt   = fpos_r;
    mem_we     = 1'b0;
    mem_waddr  = '0;
    mem_wdata  = elem_r;
    mem_re     = 1'b0;
    mem_raddr  = '0;
    out_load   = 1'b0;

    unique case (state_r)
      SQ_IDLE: begin
        if (in_valid) begin
          state_nxt = SQ_EXEC;
        end
      end

      // checks in order: null, position, full
      SQ_EXEC: begin
        status_nxt = STATUS_OK;
        eout_nxt   = '0;
        found_nxt  = 1'b0;
        fpos_nxt   = '0;
        state_nxt  = SQ_FIN;
        unique case (kind_r)
          KIND_APPEND: begin
            if (elem_null) begin
              status_nxt = STATUS_NULL;
            end else if (full) begin
              status_nxt = STATUS_FULL;
            end else begin
              mem_we    = 1'b1;
              mem_waddr = AW'(count_r);
              count_nxt = count_r + CNT_W'(1);
            end
          end
          KIND_GET, KIND_REMOVE: begin
            if (pos_w >= cnt_w) begin
              status_nxt = STATUS_RANGE;
            end else begin
              mem_re    = 1'b1;
              mem_raddr = AW'(pos_r);
              idx_nxt   = CNT_W'(pos_r);
              state_nxt = SQ_PICK;
            end
          end
          KIND_SET, KIND_INSERT: begin
            if (elem_null) begin
              status_nxt = STATUS_NULL;
            end else if (pos_w > cnt_w) begin
              status_nxt = STATUS_RANGE;
            end else if (pos_w == cnt_w) begin
              // at the end both act as append
              if (full) begin
                status_nxt = STATUS_FULL;
              end else begin
                mem_we    = 1'b1;
                mem_waddr = AW'(count_r);
                count_nxt = count_r + CNT_W'(1);
              end
            end else if (kind_r == KIND_SET) begin
              mem_we    = 1'b1;
              mem_waddr = AW'(pos_r);
            end else if (full) begin
              status_nxt = STATUS_FULL;
            end else begin
              // open a gap: start from the last entry
              mem_re    = 1'b1;
              mem_raddr = AW'(count_r - CNT_W'(1));
              idx_nxt   = count_r;
              state_nxt = SQ_SHUP;
            end
          end
          KIND_FIND: begin
            if (elem_null) begin
              status_nxt = STATUS_NULL;
            end else if (count_r != '0) begin
              mem_re    = 1'b1;
              mem_raddr = '0;
              idx_nxt   = '0;
              state_nxt = SQ_FIND;
            end
          end
          KIND_CLEAR: begin
            count_nxt = '0;
          end
          default: begin
          end
        endcase
      end

      // read data for get and remove
      SQ_PICK: begin
        eout_nxt = mem_rdata;
        if (kind_r == KIND_GET) begin
          state_nxt = SQ_FIN;
        end else if (idx_w + XW'(1) < cnt_w) begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_w + XW'(1));
          state_nxt = SQ_SHDN;
        end else begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = SQ_FIN;
        end
      end

      // entry idx-1 moves to idx
      SQ_SHUP: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        mem_wdata = mem_rdata;
        if (idx_w - XW'(1) == pos_w) begin
          state_nxt = SQ_TAIL;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_w - XW'(2));
          idx_nxt   = idx_r - CNT_W'(1);
        end
      end

      SQ_TAIL: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(pos_r);
        count_nxt = count_r + CNT_W'(1);
        state_nxt = SQ_FIN;
      end

      // entry idx+1 moves to idx
      SQ_SHDN: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(idx_r);
        mem_wdata = mem_rdata;
        if (idx_w + XW'(2) == cnt_w) begin
          count_nxt = count_r - CNT_W'(1);
          state_nxt = SQ_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_w + XW'(2));
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end

      // compare one entry per cycle, stop at the first match
      SQ_FIND: begin
        if (mem_rdata == elem_r) begin
          found_nxt = 1'b1;
          fpos_nxt  = idx_r;
          state_nxt = SQ_FIN;
        end else if (idx_w + XW'(1) == cnt_w) begin
          state_nxt = SQ_FIN;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = AW'(idx_w + XW'(1));
          idx_nxt   = idx_r + CNT_W'(1);
        end
      end

      SQ_FIN: begin
        if (out_free) begin
          out_load  = 1'b1;
          state_nxt = SQ_IDLE;
        end
      end

      default: begin
        state_nxt = SQ_IDLE;
      end
    endcase
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_rsp_r.status         <= status_r;
      out_rsp_r.element_out    <= 32'(eout_r[EW-1:0]);
      out_rsp_r.found_position <= 8'(fpos_r);
      out_rsp_r.found          <= found_r;
      out_rsp_r.count          <= 9'(count_r);
      out_rsp_r.empty_res      <= (count_r == '0);
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

endmodule

`default_nettype wire

@@ hw/rtl/ils_checker.sv @@
// ils_checker: port-level checks for the indexed list store
// depends on ils_pkg; bound to indexed_list_store below
`default_nettype none

module ils_checker (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_stall,
  input wire logic          out_valid,
  input wire logic          out_stall,
  input wire ils_pkg::rsp_t out_rsp
);

  import ils_pkg::*;

  // busy in the cycle after a request is taken
  a_busy_after_take: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("request taken while previous one still in work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_rsp))
    else $error("stalled result changed");

  // a match is only reported with ok status
  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.found |-> out_rsp.status == STATUS_OK)
    else $error("found set on failed request");

  // errors carry no element and no match
  a_err_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rsp.status != STATUS_OK
      |-> out_rsp.element_out == '0 && !out_rsp.found && out_rsp.found_position == '0)
    else $error("error result carries data");

endmodule

bind indexed_list_store ils_checker u_ils_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_rsp   (out_rsp)
);

`default_nettype wire

@@ tb/sv/tb_indexed_list_store.sv @@
// tb_indexed_list_store: self-checking bench for the indexed list store
// a table of directed requests, then random request streams, scored against typed-in results or a list predictor
// depends on ils_pkg and indexed_list_store
module tb_indexed_list_store;
  timeunit 1ns;
  timeprecision 1ps;

  import ils_pkg::*;

  localparam int          CAPACITY    = CAPACITY_DEF;
  localparam int          RANDOM_REQS = 2000;
  localparam int          CYCLE_LIMIT = 3_000_000;
  localparam int          DRAIN_WAIT  = CAPACITY + 40;
  // the one code with no operation behind it
  localparam logic [2:0]  KIND_UNUSED = 3'd7;

  // random stream flavors: fill the list, churn it, or drain it
  typedef enum {
    MODE_GROW,
    MODE_MIXED,
    MODE_SHRINK
  } list_mode_t;

  // one row of the directed table; fill rows append until the list is full
  typedef struct {
    req_t req;
    bit   fill;
    bit   typed;
    rsp_t want;
  } table_row_t;

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  req_t  in_req;
  logic  out_valid;
  logic  out_stall;
  rsp_t  out_rsp;

  // predictor copy of the list
  logic [31:0] list_entries [CAPACITY];
  int unsigned list_count;

  rsp_t        pending_results[$];
  table_row_t  directed_rows[$];
  logic [31:0] handle_pool[16];
  int          error_count;
  int unsigned cycle_count;
  int          burst_left;

  indexed_list_store u_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_req    (in_req),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_rsp   (out_rsp)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // watchdog: sized for every request taking the full shift or search plus long stalls
  initial begin : watchdog
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Some tests failed");
    $finish;
  end

  // one printed line per mismatch
  task automatic report_mismatch(string what, longint unsigned got, longint unsigned want);
    $display("[%0t] mismatch on %s: got %0h, expected %0h", $realtime, what, got, want);
    error_count++;
  endtask

  // list behavior: one request in, one result out, predictor state updated in place
  function automatic rsp_t apply_list_op(req_t r);
    rsp_t        rsp;
    logic [31:0] handle;
    int unsigned pos;
    bit          full;
    int unsigned i;
    rsp    = '0;
    handle = r.element;
    pos    = 32'(r.position);
    full   = (list_count >= CAPACITY);
    unique case (r.kind)
      KIND_APPEND: begin
        if (handle == '0) rsp.status = STATUS_NULL;
        else if (full) rsp.status = STATUS_FULL;
        else begin
          list_entries[list_count] = handle;
          list_count++;
        end
      end
      KIND_GET: begin
        if (pos >= list_count) rsp.status = STATUS_RANGE;
        else rsp.element_out = list_entries[pos];
      end
      KIND_SET, KIND_INSERT: begin
        if (handle == '0) rsp.status = STATUS_NULL;
        else if (pos > list_count) rsp.status = STATUS_RANGE;
        else if (pos == list_count) begin
          // writing at the tail is an append for both
          if (full) rsp.status = STATUS_FULL;
          else begin
            list_entries[list_count] = handle;
            list_count++;
          end
        end else if (r.kind == KIND_SET) begin
          list_entries[pos] = handle;
        end else if (full) begin
          rsp.status = STATUS_FULL;
        end else begin
          for (i = list_count; i > pos; i--) list_entries[i] = list_entries[i - 1];
          list_entries[pos] = handle;
          list_count++;
        end
      end
      KIND_REMOVE: begin
        if (pos >= list_count) rsp.status = STATUS_RANGE;
        else begin
          rsp.element_out = list_entries[pos];
          for (i = pos; i + 1 < list_count; i++) list_entries[i] = list_entries[i + 1];
          list_count--;
        end
      end
      KIND_FIND: begin
        if (handle == '0) rsp.status = STATUS_NULL;
        else begin
          for (i = 0; i < list_count; i++) begin
            if (list_entries[i] == handle && !rsp.found) begin
              rsp.found          = 1'b1;
              rsp.found_position = i[7:0];
            end
          end
        end
      end
      KIND_CLEAR: list_count = 0;
      default: ;
    endcase
    rsp.count     = list_count[8:0];
    rsp.empty_res = (list_count == 0);
    return rsp;
  endfunction

  // request driver: bursts of back-to-back requests with random idle gaps between
  task automatic issue_request(req_t r, bit typed, rsp_t want);
    int   gap;
    rsp_t predicted;
    gap = 0;
    if (burst_left == 0) begin
      gap        = $urandom_range(1, 12);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(60, 200) : $urandom_range(1, 30);
    end
    burst_left--;
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid <= 1'b1;
    in_req   <= r;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    // request taken at this edge: predict now, keep the typed-in value where there is one
    predicted = apply_list_op(r);
    pending_results.push_back(typed ? want : predicted);
  endtask

  function automatic void add_row(bit fill, bit typed, logic [2:0] kind, logic [8:0] pos,
                                  logic [31:0] elem, status_t st, logic [31:0] eout,
                                  int unsigned cnt);
    table_row_t row;
    row.req                 = '{kind: kind, position: pos, element: elem};
    row.fill                = fill;
    row.typed               = typed;
    row.want                = '0;
    row.want.status         = st;
    row.want.element_out    = eout;
    row.want.count          = cnt[8:0];
    row.want.empty_res      = (cnt == 0);
    directed_rows.push_back(row);
  endfunction

  // handles mostly come from a small pool so find and overwrite hit stored entries
  function automatic logic [31:0] pick_handle();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 65) return handle_pool[$urandom_range(0, 15)];
    if (pick < 97) return $urandom;
    return '0;
  endfunction

  // positions cluster inside the list, at its tail and just past it
  function automatic logic [8:0] pick_position();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 72 && list_count > 0) return 9'($urandom_range(0, list_count - 1));
    if (pick < 84) return 9'(list_count);
    if (pick < 92) return 9'(list_count + 1);
    return 9'($urandom);
  endfunction

  function automatic req_t next_random_request(list_mode_t mode);
    req_t        r;
    int unsigned pick;
    r    = '0;
    pick = $urandom_range(0, 99);
    // a few raw requests: any kind, any position, any handle
    if (pick < 5) begin
      r.kind     = 3'($urandom);
      r.position = 9'($urandom);
      r.element  = $urandom;
      return r;
    end
    pick = $urandom_range(0, 99);
    unique case (mode)
      MODE_GROW: begin
        if (pick < 45) r.kind = KIND_APPEND;
        else if (pick < 70) r.kind = KIND_INSERT;
        else if (pick < 78) r.kind = KIND_SET;
        else if (pick < 86) r.kind = KIND_FIND;
        else if (pick < 93) r.kind = KIND_GET;
        else r.kind = KIND_REMOVE;
      end
      MODE_MIXED: begin
        if (pick < 15) r.kind = KIND_APPEND;
        else if (pick < 30) r.kind = KIND_INSERT;
        else if (pick < 45) r.kind = KIND_SET;
        else if (pick < 60) r.kind = KIND_GET;
        else if (pick < 76) r.kind = KIND_REMOVE;
        else if (pick < 99) r.kind = KIND_FIND;
        else r.kind = KIND_CLEAR;
      end
      default: begin
        if (pick < 55) r.kind = KIND_REMOVE;
        else if (pick < 65) r.kind = KIND_GET;
        else if (pick < 80) r.kind = KIND_FIND;
        else if (pick < 88) r.kind = KIND_SET;
        else if (pick < 95) r.kind = KIND_APPEND;
        else if (pick < 98) r.kind = KIND_INSERT;
        else r.kind = KIND_CLEAR;
      end
    endcase
    r.position = pick_position();
    r.element  = pick_handle();
    return r;
  endfunction

  // result checker: every accepted result against the oldest pending prediction
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 64'(out_rsp), 64'(0));
      end else begin
        rsp_t want;
        want = pending_results.pop_front();
        if (out_rsp.status !== want.status)
          report_mismatch("status", 64'(out_rsp.status), 64'(want.status));
        if (out_rsp.element_out !== want.element_out)
          report_mismatch("element_out", 64'(out_rsp.element_out), 64'(want.element_out));
        if (out_rsp.found_position !== want.found_position)
          report_mismatch("found_position", 64'(out_rsp.found_position),
                          64'(want.found_position));
        if (out_rsp.found !== want.found)
          report_mismatch("found", 64'(out_rsp.found), 64'(want.found));
        if (out_rsp.count !== want.count)
          report_mismatch("count", 64'(out_rsp.count), 64'(want.count));
        if (out_rsp.empty_res !== want.empty_res)
          report_mismatch("empty_res", 64'(out_rsp.empty_res), 64'(want.empty_res));
      end
    end
  end

  // result side: stretches of free flow, light stalls, heavy stalls and periodic stalls
  initial begin : result_sink
    int run_left;
    int style;
    int period;
    int phase;
    out_stall = 1'b0;
    run_left  = 0;
    style     = 0;
    period    = 2;
    phase     = 0;
    forever begin
      @(negedge clk);
      if (run_left == 0) begin
        style    = $urandom_range(0, 3);
        run_left = $urandom_range(20, 300);
        period   = $urandom_range(2, 7);
        phase    = 0;
      end
      run_left--;
      phase++;
      unique case (style)
        0: out_stall <= 1'b0;
        1: out_stall <= ($urandom_range(0, 3) == 0);
        2: out_stall <= ($urandom_range(0, 3) != 0);
        default: out_stall <= ((phase % period) < (period / 2));
      endcase
    end
  end

  initial begin : stimulus
    list_mode_t  mode;
    int          mode_left;
    int          full_hits;
    int          sent;
    int unsigned pick;
    req_t        r;
    rsp_t        none;

    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_req       = '0;
    error_count  = 0;
    burst_left   = 0;
    list_count   = 0;
    none         = '0;

    handle_pool[0] = 32'hFFFF_FFFF;
    handle_pool[1] = 32'h0000_0001;
    for (int k = 2; k < 16; k++) handle_pool[k] = $urandom_range(1, 32'hFFFF_FFFF);

    // directed table; typed-in results where they follow directly from the request
    // empty list: out-of-range reads, null handles
    add_row(0, 1, KIND_GET,    9'd0,     32'h0,         STATUS_RANGE, 32'h0, 0);
    add_row(0, 1, KIND_REMOVE, 9'd0,     32'h0,         STATUS_RANGE, 32'h0, 0);
    add_row(0, 1, KIND_APPEND, 9'd0,     32'h0,         STATUS_NULL,  32'h0, 0);
    add_row(0, 1, KIND_FIND,   9'd0,     32'h0,         STATUS_NULL,  32'h0, 0);
    // handle extremes
    add_row(0, 1, KIND_APPEND, 9'd0,     32'hFFFF_FFFF, STATUS_OK,    32'h0, 1);
    add_row(0, 1, KIND_APPEND, 9'h1FF,   32'h0000_0001, STATUS_OK,    32'h0, 2);
    add_row(0, 1, KIND_GET,    9'd0,     32'h0,         STATUS_OK,    32'hFFFF_FFFF, 2);
    add_row(0, 1, KIND_GET,    9'h1FF,   32'h0,         STATUS_RANGE, 32'h0, 2);
    // overwrite at the tail appends, past the tail is out of range
    add_row(0, 1, KIND_SET,    9'd2,     32'hA5A5_5A5A, STATUS_OK,    32'h0, 3);
    add_row(0, 1, KIND_SET,    9'd4,     32'h0000_0007, STATUS_RANGE, 32'h0, 3);
    // null is checked ahead of the position
    add_row(0, 1, KIND_SET,    9'h100,   32'h0,         STATUS_NULL,  32'h0, 3);
    add_row(0, 0, KIND_SET,    9'd1,     32'h0000_0005, STATUS_OK,    32'h0, 0);
    // insert at the head shifts everything, at the tail it appends
    add_row(0, 0, KIND_INSERT, 9'd0,     32'h8000_0000, STATUS_OK,    32'h0, 0);
    add_row(0, 0, KIND_INSERT, 9'd4,     32'h0000_0002, STATUS_OK,    32'h0, 0);
    add_row(0, 1, KIND_INSERT, 9'h1FF,   32'h0000_0003, STATUS_RANGE, 32'h0, 5);
    add_row(0, 1, KIND_INSERT, 9'h1FF,   32'h0,         STATUS_NULL,  32'h0, 5);
    add_row(0, 0, KIND_FIND,   9'd0,     32'h0000_0005, STATUS_OK,    32'h0, 0);
    add_row(0, 1, KIND_FIND,   9'd0,     32'h0000_0009, STATUS_OK,    32'h0, 5);
    add_row(0, 0, KIND_REMOVE, 9'd0,     32'h0,         STATUS_OK,    32'h0, 0);
    add_row(0, 1, KIND_REMOVE, 9'd4,     32'h0,         STATUS_RANGE, 32'h0, 4);
    // the unused code leaves the list alone
    add_row(0, 1, KIND_UNUSED, 9'h1FF,   32'hFFFF_FFFF, STATUS_OK,    32'h0, 4);
    add_row(0, 1, KIND_CLEAR,  9'd0,     32'h0,         STATUS_OK,    32'h0, 0);
    // full list: every growing request is refused, range still wins over full
    add_row(1, 0, KIND_APPEND, 9'd0,     32'h0,         STATUS_OK,    32'h0, 0);
    add_row(0, 1, KIND_APPEND, 9'd0,     32'h0000_0004, STATUS_FULL,  32'h0, CAPACITY);
    add_row(0, 1, KIND_SET,    9'h100,   32'h0000_0004, STATUS_FULL,  32'h0, CAPACITY);
    add_row(0, 1, KIND_INSERT, 9'd0,     32'h0000_0004, STATUS_FULL,  32'h0, CAPACITY);
    add_row(0, 1, KIND_SET,    9'h101,   32'h0000_0004, STATUS_RANGE, 32'h0, CAPACITY);
    add_row(0, 0, KIND_FIND,   9'd0,     32'hFFFF_FFFF, STATUS_OK,    32'h0, 0);
    add_row(0, 0, KIND_REMOVE, 9'd255,   32'h0,         STATUS_OK,    32'h0, 0);
    add_row(0, 0, KIND_REMOVE, 9'd0,     32'h0,         STATUS_OK,    32'h0, 0);

    repeat (5) @(negedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[n]) begin
      if (directed_rows[n].fill) begin
        while (list_count < CAPACITY) begin
          r         = '0;
          r.kind    = KIND_APPEND;
          r.element = ($urandom_range(0, 1) != 0) ? handle_pool[$urandom_range(0, 15)]
                                                  : $urandom_range(1, 32'hFFFF_FFFF);
          issue_request(r, 1'b0, none);
        end
      end else begin
        issue_request(directed_rows[n].req, directed_rows[n].typed, directed_rows[n].want);
      end
    end

    // random part: mostly fill / churn / drain runs, sprinkled with raw requests
    mode      = MODE_GROW;
    mode_left = 0;
    full_hits = 0;
    sent      = 0;
    while (sent < RANDOM_REQS) begin
      r = next_random_request(mode);
      issue_request(r, 1'b0, none);
      if (r.kind != KIND_UNUSED) sent++;
      if (mode == MODE_GROW) begin
        // stay at capacity for a while so the full cases get hit repeatedly
        if (list_count == CAPACITY) full_hits++;
        if (full_hits >= 12) mode_left = 1;
        else mode_left = 2;
      end
      mode_left--;
      if (mode_left <= 0) begin
        pick      = $urandom_range(0, 99);
        mode      = (pick < 45) ? MODE_GROW : (pick < 80) ? MODE_MIXED : MODE_SHRINK;
        mode_left = $urandom_range(30, 200);
        full_hits = 0;
      end
    end

    @(negedge clk);
    in_valid <= 1'b0;

    // drain, then give the block time to show any stray result
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
